FILE: rtl/core/rlt_pkg.sv
// shared types, request and status codes for the record lock table
`timescale 1ns / 1ps

package rlt_pkg;

   // default table capacity
   localparam int ENTRIES_DEFAULT = 64;

   // field widths
   localparam int OP_W      = 3;
   localparam int SESSION_W = 16;
   localparam int FILE_W    = 16;
   localparam int RECORD_W  = 32;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 7;

   // request codes
   localparam logic [OP_W-1:0] OP_ACQUIRE      = 3'd0;
   localparam logic [OP_W-1:0] OP_RELEASE      = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE_SESS = 3'd2;
   localparam logic [OP_W-1:0] OP_RELEASE_FILE = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP       = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HELD     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   // removed count saturates here
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [SESSION_W-1:0] session;
      logic [FILE_W-1:0]    file;
      logic [RECORD_W-1:0]  record;
      logic                 kind;
   } request_type;

   typedef struct packed {
      logic                 ok;
      logic [STATUS_W-1:0]  status;
      logic [SESSION_W-1:0] holder_session;
      logic                 holder_type;
   } result_type;

endpackage

FILE: rtl/core/rlt_table.sv
// lock entry storage with parallel match, decision and update
`timescale 1ns / 1ps

module rlt_table #(
   parameter int ENTRIES = rlt_pkg::ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  rlt_pkg::request_type request,
   output rlt_pkg::result_type  result,
   output logic [ENTRIES-1:0]   removed_mask
);

   logic [ENTRIES-1:0]                 valid_ff;
   logic [rlt_pkg::FILE_W-1:0]         file_ff   [ENTRIES];
   logic [rlt_pkg::RECORD_W-1:0]       record_ff [ENTRIES];
   logic [rlt_pkg::SESSION_W-1:0]      owner_ff  [ENTRIES];
   logic [ENTRIES-1:0]                 kind_ff;

   logic [ENTRIES-1:0] key_match;
   logic [ENTRIES-1:0] sess_match;
   logic [ENTRIES-1:0] file_match;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] free_first;
   logic [ENTRIES-1:0] wr_mask;
   logic [ENTRIES-1:0] clr_mask;
   logic               found;
   logic [rlt_pkg::SESSION_W-1:0] found_owner;
   logic               found_kind;
   logic               key_bad;

   // parallel compare against every entry
   always_comb begin
      found_owner = '0;
      found_kind  = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         key_match[i]  = valid_ff[i] && (file_ff[i] == request.file)
                         && (record_ff[i] == request.record);
         sess_match[i] = valid_ff[i] && (owner_ff[i] == request.session);
         file_match[i] = valid_ff[i] && (file_ff[i] == request.file);
         // keys are unique, so at most one entry contributes
         found_owner   = found_owner | (key_match[i] ? owner_ff[i] : '0);
         found_kind    = found_kind | (key_match[i] & kind_ff[i]);
      end
      found      = |key_match;
      free_vec   = ~valid_ff;
      // isolate the lowest free slot
      free_first = free_vec & (~free_vec + ENTRIES'(1));
   end

   // decide result and table changes
   always_comb begin
      result       = '0;
      result.status = rlt_pkg::ST_INVALID;
      wr_mask      = '0;
      clr_mask     = '0;
      removed_mask = '0;
      key_bad      = (request.session == '0) || (request.file == '0)
                     || (request.record == '0);
      case (request.op)
         rlt_pkg::OP_ACQUIRE, rlt_pkg::OP_RELEASE: begin
            if (!key_bad) begin
               if (found && (found_owner != request.session)) begin
                  result.status         = rlt_pkg::ST_HELD;
                  result.holder_session = found_owner;
                  result.holder_type    = found_kind;
               end else if (request.op == rlt_pkg::OP_ACQUIRE) begin
                  if (found) begin
                     wr_mask       = key_match;
                     result.ok     = 1'b1;
                     result.status = rlt_pkg::ST_DONE;
                  end else if (|free_vec) begin
                     wr_mask       = free_first;
                     result.ok     = 1'b1;
                     result.status = rlt_pkg::ST_DONE;
                  end else begin
                     result.status = rlt_pkg::ST_FULL;
                  end
               end else if (!found) begin
                  result.status = rlt_pkg::ST_NOTFOUND;
               end else begin
                  clr_mask      = key_match;
                  result.ok     = 1'b1;
                  result.status = rlt_pkg::ST_DONE;
               end
            end
         end
         rlt_pkg::OP_RELEASE_SESS: begin
            if (request.session != '0) begin
               clr_mask      = sess_match;
               removed_mask  = sess_match;
               result.ok     = 1'b1;
               result.status = rlt_pkg::ST_DONE;
            end
         end
         rlt_pkg::OP_RELEASE_FILE: begin
            if (request.file != '0) begin
               clr_mask      = file_match;
               removed_mask  = file_match;
               result.ok     = 1'b1;
               result.status = rlt_pkg::ST_DONE;
            end
         end
         rlt_pkg::OP_LOOKUP: begin
            if ((request.file != '0) && (request.record != '0)) begin
               if (found) begin
                  result.ok             = 1'b1;
                  result.status         = rlt_pkg::ST_DONE;
                  result.holder_session = found_owner;
                  result.holder_type    = found_kind;
               end else begin
                  result.status = rlt_pkg::ST_NOTFOUND;
               end
            end
         end
         default: begin
            result.status = rlt_pkg::ST_INVALID;
         end
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= (valid_ff & ~clr_mask) | wr_mask;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (wr_mask[i]) begin
               file_ff[i]   <= request.file;
               record_ff[i] <= request.record;
               owner_ff[i]  <= request.session;
               kind_ff[i]   <= request.kind;
            end
         end
      end
   end

endmodule

FILE: rtl/core/record_lock_table.sv
// record lock table top level: request register, table stage, count stage
`timescale 1ns / 1ps

// Record lock table with ENTRIES slots, each holding file id, record id, owning
// session and lock type, empty after reset. One request is accepted per clock
// when the response side is not stalling; its response passes through the table
// stage into the result register and then the count stage into the output register.
// The request register feeds a parallel match over all
// slots, which updates the table in the same cycle it registers the result, so
// back-to-back requests always see each other's effects. Release-all counts
// are summed over groups of eight slots in a final stage and saturate at 127.
// A response stall with a response held holds the pipeline and raises req_stall.

module record_lock_table #(
   parameter int ENTRIES = rlt_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rlt_pkg::OP_W-1:0]       req_type,
   input  logic [rlt_pkg::SESSION_W-1:0]  req_session_id,
   input  logic [rlt_pkg::FILE_W-1:0]     req_file_id,
   input  logic [rlt_pkg::RECORD_W-1:0]   req_record_id,
   input  logic                           req_lock_type,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_ok,
   output logic [rlt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rlt_pkg::COUNT_W-1:0]    rsp_removed_count,
   output logic [rlt_pkg::SESSION_W-1:0]  rsp_holder_session,
   output logic                           rsp_holder_type
);

   localparam int GROUP   = 8;
   localparam int GROUPS  = (ENTRIES + GROUP - 1) / GROUP;
   localparam int GRP_W   = $clog2(GROUP + 1);
   localparam int SUM_W0  = $clog2(ENTRIES + 1);
   localparam int SUM_W   = (SUM_W0 > rlt_pkg::COUNT_W) ? SUM_W0 : rlt_pkg::COUNT_W;

   logic                  advance;
   logic                  s0_valid_ff;
   rlt_pkg::request_type  s0_req_ff;
   logic                  s1_valid_ff;
   rlt_pkg::result_type   s1_res_ff;
   logic [GRP_W-1:0]      s1_grp_ff [GROUPS];
   logic [GRP_W-1:0]      s1_grp_in [GROUPS];
   logic                  s2_valid_ff;
   rlt_pkg::result_type   s2_res_ff;
   logic [rlt_pkg::COUNT_W-1:0] s2_count_ff;
   logic [rlt_pkg::COUNT_W-1:0] s2_count_in;
   logic [SUM_W-1:0]      count_sum;

   rlt_pkg::request_type  req_in;
   rlt_pkg::result_type   tbl_result;
   logic [ENTRIES-1:0]    tbl_removed;
   logic [GROUPS*GROUP-1:0] removed_pad;

   // whole pipeline moves unless the held response is stalled
   assign advance   = !s2_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign req_in.op      = req_type;
   assign req_in.session = req_session_id;
   assign req_in.file    = req_file_id;
   assign req_in.record  = req_record_id;
   assign req_in.kind    = req_lock_type;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         s0_req_ff <= req_in;
      end
   end

   // table match and update
   rlt_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance && s0_valid_ff),
      .request      (s0_req_ff),
      .result       (tbl_result),
      .removed_mask (tbl_removed)
   );

   // per-group count of freed slots
   always_comb begin
      removed_pad = '0;
      removed_pad[ENTRIES-1:0] = tbl_removed;
      for (int g = 0; g < GROUPS; g++) begin
         s1_grp_in[g] = '0;
         for (int b = 0; b < GROUP; b++) begin
            s1_grp_in[g] = s1_grp_in[g] + GRP_W'(removed_pad[g*GROUP + b]);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_res_ff <= tbl_result;
         for (int g = 0; g < GROUPS; g++) begin
            s1_grp_ff[g] <= s1_grp_in[g];
         end
      end
   end

   // sum the groups and saturate
   always_comb begin
      count_sum = '0;
      for (int g = 0; g < GROUPS; g++) begin
         count_sum = count_sum + SUM_W'(s1_grp_ff[g]);
      end
      if (count_sum > SUM_W'(rlt_pkg::COUNT_MAX)) begin
         s2_count_in = rlt_pkg::COUNT_MAX;
      end else begin
         s2_count_in = count_sum[rlt_pkg::COUNT_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_res_ff   <= s1_res_ff;
         s2_count_ff <= s2_count_in;
      end
   end

   assign rsp_valid          = s2_valid_ff;
   assign rsp_ok             = s2_res_ff.ok;
   assign rsp_status         = s2_res_ff.status;
   assign rsp_removed_count  = s2_count_ff;
   assign rsp_holder_session = s2_res_ff.holder_session;
   assign rsp_holder_type    = s2_res_ff.holder_type;

endmodule

FILE: bench/record_lock_table_tb.sv
// self-checking testbench for the record lock table
`timescale 1ns / 1ps

module record_lock_table_tb;

   localparam int SLOTS = rlt_pkg::ENTRIES_DEFAULT;

   // request codes the block must refuse as unknown
   localparam logic [rlt_pkg::OP_W-1:0] OP_BAD_LO  = 3'd5;
   localparam logic [rlt_pkg::OP_W-1:0] OP_BAD_MID = 3'd6;
   localparam logic [rlt_pkg::OP_W-1:0] OP_BAD_HI  = 3'd7;

   typedef struct packed {
      logic                          ok;
      logic [rlt_pkg::STATUS_W-1:0]  status;
      logic [rlt_pkg::COUNT_W-1:0]   removed;
      logic [rlt_pkg::SESSION_W-1:0] holder_session;
      logic                          holder_type;
   } lock_reply_type;

   typedef struct packed {
      logic [rlt_pkg::OP_W-1:0]      op;
      logic [rlt_pkg::SESSION_W-1:0] session;
      logic [rlt_pkg::FILE_W-1:0]    file;
      logic [rlt_pkg::RECORD_W-1:0]  record;
      logic                          kind;
      bit                            typed;
      lock_reply_type                reply;
   } stim_row_type;

   // replies that can be read off directly
   localparam lock_reply_type R_NONE     = '0;
   localparam lock_reply_type R_INVALID  = '{1'b0, rlt_pkg::ST_INVALID, 7'd0, 16'd0, 1'b0};
   localparam lock_reply_type R_NOTFOUND = '{1'b0, rlt_pkg::ST_NOTFOUND, 7'd0, 16'd0, 1'b0};
   localparam lock_reply_type R_DONE     = '{1'b1, rlt_pkg::ST_DONE, 7'd0, 16'd0, 1'b0};
   localparam lock_reply_type R_HELD_MAX = '{1'b0, rlt_pkg::ST_HELD, 7'd0, 16'hFFFF, 1'b1};

   // directed requests: empty keys, unknown codes, extremes, conflicts
   localparam stim_row_type DIRECTED [25] = '{
      '{rlt_pkg::OP_LOOKUP,       16'd1,    16'd1,    32'd1,        1'b0, 1'b1, R_NOTFOUND},
      '{rlt_pkg::OP_ACQUIRE,      16'd0,    16'd1,    32'd1,        1'b0, 1'b1, R_INVALID},
      '{rlt_pkg::OP_ACQUIRE,      16'd1,    16'd0,    32'd1,        1'b0, 1'b1, R_INVALID},
      '{rlt_pkg::OP_ACQUIRE,      16'd1,    16'd1,    32'd0,        1'b0, 1'b1, R_INVALID},
      '{rlt_pkg::OP_RELEASE,      16'd0,    16'd1,    32'd1,        1'b0, 1'b1, R_INVALID},
      '{OP_BAD_LO,                16'd1,    16'd1,    32'd1,        1'b1, 1'b1, R_INVALID},
      '{OP_BAD_MID,               16'd1,    16'd1,    32'd1,        1'b0, 1'b1, R_INVALID},
      '{OP_BAD_HI,                16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, R_INVALID},
      '{rlt_pkg::OP_ACQUIRE,      16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, R_DONE},
      '{rlt_pkg::OP_LOOKUP,       16'd1,    16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b1,
        '{1'b1, rlt_pkg::ST_DONE, 7'd0, 16'hFFFF, 1'b1}},
      '{rlt_pkg::OP_ACQUIRE,      16'd1,    16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, R_HELD_MAX},
      '{rlt_pkg::OP_RELEASE,      16'd1,    16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, R_HELD_MAX},
      '{rlt_pkg::OP_ACQUIRE,      16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, R_DONE},
      '{rlt_pkg::OP_LOOKUP,       16'd9,    16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, R_NONE},
      '{rlt_pkg::OP_ACQUIRE,      16'd1,    16'd1,    32'd1,        1'b1, 1'b0, R_NONE},
      '{rlt_pkg::OP_ACQUIRE,      16'd2,    16'd1,    32'd2,        1'b0, 1'b0, R_NONE},
      '{rlt_pkg::OP_RELEASE_SESS, 16'd0,    16'd1,    32'd1,        1'b0, 1'b1, R_INVALID},
      '{rlt_pkg::OP_RELEASE_FILE, 16'd1,    16'd0,    32'd1,        1'b0, 1'b1, R_INVALID},
      '{rlt_pkg::OP_LOOKUP,       16'd1,    16'd0,    32'd5,        1'b0, 1'b1, R_INVALID},
      '{rlt_pkg::OP_LOOKUP,       16'd1,    16'd5,    32'd0,        1'b0, 1'b1, R_INVALID},
      '{rlt_pkg::OP_RELEASE_SESS, 16'd1,    16'd9,    32'd9,        1'b0, 1'b1,
        '{1'b1, rlt_pkg::ST_DONE, 7'd1, 16'd0, 1'b0}},
      '{rlt_pkg::OP_RELEASE,      16'd2,    16'd1,    32'd2,        1'b0, 1'b0, R_NONE},
      '{rlt_pkg::OP_RELEASE,      16'd2,    16'd1,    32'd2,        1'b0, 1'b1, R_NOTFOUND},
      '{rlt_pkg::OP_RELEASE_FILE, 16'd3,    16'hFFFF, 32'd3,        1'b0, 1'b1,
        '{1'b1, rlt_pkg::ST_DONE, 7'd1, 16'd0, 1'b0}},
      '{rlt_pkg::OP_RELEASE_SESS, 16'd7,    16'd7,    32'd7,        1'b0, 1'b1, R_DONE}
   };

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [rlt_pkg::OP_W-1:0]      req_type;
   logic [rlt_pkg::SESSION_W-1:0] req_session_id;
   logic [rlt_pkg::FILE_W-1:0]    req_file_id;
   logic [rlt_pkg::RECORD_W-1:0]  req_record_id;
   logic                          req_lock_type;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_ok;
   logic [rlt_pkg::STATUS_W-1:0]  rsp_status;
   logic [rlt_pkg::COUNT_W-1:0]   rsp_removed_count;
   logic [rlt_pkg::SESSION_W-1:0] rsp_holder_session;
   logic                          rsp_holder_type;

   // lock table as the bench sees it
   bit                            slot_used   [SLOTS];
   logic [rlt_pkg::FILE_W-1:0]    slot_file   [SLOTS];
   logic [rlt_pkg::RECORD_W-1:0]  slot_record [SLOTS];
   logic [rlt_pkg::SESSION_W-1:0] slot_owner  [SLOTS];
   logic                          slot_kind   [SLOTS];

   lock_reply_type replies_due[$];
   int          failures = 0;
   int          requests_sent = 0;
   int          status_hits [8];
   int          largest_release = 0;
   bit          quiet = 1'b0;

   record_lock_table dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_session_id     (req_session_id),
      .req_file_id        (req_file_id),
      .req_record_id      (req_record_id),
      .req_lock_type      (req_lock_type),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_status         (rsp_status),
      .rsp_removed_count  (rsp_removed_count),
      .rsp_holder_session (rsp_holder_session),
      .rsp_holder_type    (rsp_holder_type)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // slot holding a key, or -1
   function automatic int find_key(input logic [rlt_pkg::FILE_W-1:0] f,
                                   input logic [rlt_pkg::RECORD_W-1:0] r);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_file[i] == f && slot_record[i] == r) return i;
      return -1;
   endfunction

   // first occupied slot at or after start, wrapping, or -1
   function automatic int pick_slot(input int start);
      int idx;
      for (int i = 0; i < SLOTS; i++) begin
         idx = (start + i) % SLOTS;
         if (slot_used[idx]) return idx;
      end
      return -1;
   endfunction

   // table update and reply for one request
   function automatic lock_reply_type apply_request(input rlt_pkg::request_type r);
      lock_reply_type y;
      int hit;
      y = R_INVALID;
      case (r.op)
         rlt_pkg::OP_ACQUIRE, rlt_pkg::OP_RELEASE: begin
            if (r.session != 0 && r.file != 0 && r.record != 0) begin
               hit = find_key(r.file, r.record);
               if (hit >= 0 && slot_owner[hit] != r.session) begin
                  y.status = rlt_pkg::ST_HELD;
                  y.holder_session = slot_owner[hit];
                  y.holder_type = slot_kind[hit];
               end else if (r.op == rlt_pkg::OP_ACQUIRE) begin
                  // new locks take the lowest free slot
                  for (int i = 0; i < SLOTS && hit < 0; i++)
                     if (!slot_used[i]) hit = i;
                  if (hit < 0) begin
                     y.status = rlt_pkg::ST_FULL;
                  end else begin
                     slot_used[hit] = 1'b1;
                     slot_file[hit] = r.file;
                     slot_record[hit] = r.record;
                     slot_owner[hit] = r.session;
                     slot_kind[hit] = r.kind;
                     y = R_DONE;
                  end
               end else if (hit < 0) begin
                  y.status = rlt_pkg::ST_NOTFOUND;
               end else begin
                  slot_used[hit] = 1'b0;
                  y = R_DONE;
               end
            end
         end
         rlt_pkg::OP_RELEASE_SESS, rlt_pkg::OP_RELEASE_FILE: begin
            if ((r.op == rlt_pkg::OP_RELEASE_SESS && r.session != 0) ||
                (r.op == rlt_pkg::OP_RELEASE_FILE && r.file != 0)) begin
               y = R_DONE;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_used[i] && ((r.op == rlt_pkg::OP_RELEASE_SESS) ?
                      (slot_owner[i] == r.session) : (slot_file[i] == r.file))) begin
                     slot_used[i] = 1'b0;
                     if (y.removed != rlt_pkg::COUNT_MAX) y.removed++;
                  end
               end
            end
         end
         rlt_pkg::OP_LOOKUP: begin
            if (r.file != 0 && r.record != 0) begin
               hit = find_key(r.file, r.record);
               if (hit < 0) begin
                  y.status = rlt_pkg::ST_NOTFOUND;
               end else begin
                  y = R_DONE;
                  y.holder_session = slot_owner[hit];
                  y.holder_type = slot_kind[hit];
               end
            end
         end
         default: ;
      endcase
      return y;
   endfunction

   // idle cycles before the next request or response
   function automatic int idle_cycles();
      if (quiet || $urandom_range(0, 2) == 0) return 0;
      return int'($urandom_range(0, 17));
   endfunction

   // random request over small id pools so keys collide, with some wide ids and noise
   function automatic rlt_pkg::request_type random_request();
      rlt_pkg::request_type r;
      int pick;
      int slot;
      pick = int'($urandom_range(0, 99));
      r.session = 16'($urandom_range(1, 4));
      r.file = 16'($urandom_range(1, 3));
      r.record = $urandom_range(1, 24);
      r.kind = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
         r.session = 16'($urandom);
         r.file = 16'($urandom);
         r.record = $urandom;
      end
      if (pick < 45) r.op = rlt_pkg::OP_ACQUIRE;
      else if (pick < 65) r.op = rlt_pkg::OP_RELEASE;
      else if (pick < 70) r.op = rlt_pkg::OP_RELEASE_SESS;
      else if (pick < 74) r.op = rlt_pkg::OP_RELEASE_FILE;
      else if (pick < 94) r.op = rlt_pkg::OP_LOOKUP;
      else begin
         r.op = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0: r.session = '0;
            1: r.file = '0;
            2: r.record = '0;
            default: ;
         endcase
      end
      // aim most releases and lookups at live locks
      if ((r.op == rlt_pkg::OP_RELEASE || r.op == rlt_pkg::OP_LOOKUP) &&
          $urandom_range(0, 9) < 6) begin
         slot = pick_slot(int'($urandom_range(0, SLOTS - 1)));
         if (slot >= 0) begin
            r.file = slot_file[slot];
            r.record = slot_record[slot];
            if ($urandom_range(0, 3) != 0) r.session = slot_owner[slot];
         end
      end
      return r;
   endfunction

   // drive one request, wait for it to be taken, and queue its reply
   task automatic send_req(input rlt_pkg::request_type r, input bit typed,
                           input lock_reply_type typed_reply);
      int gap;
      lock_reply_type predicted;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= r.op;
      req_session_id <= r.session;
      req_file_id    <= r.file;
      req_record_id  <= r.record;
      req_lock_type  <= r.kind;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_request(r);
      replies_due.push_back(typed ? typed_reply : predicted);
      requests_sent++;
      status_hits[predicted.status]++;
      if (int'(predicted.removed) > largest_release)
         largest_release = int'(predicted.removed);
      @(negedge clock);
   endtask

   // empty the table, fill it past capacity under one file, then free that file
   task automatic fill_burst();
      rlt_pkg::request_type r;
      logic [rlt_pkg::RECORD_W-1:0] base;
      int slot;
      slot = pick_slot(0);
      while (slot >= 0) begin
         r = '{rlt_pkg::OP_RELEASE_FILE, 16'd1, slot_file[slot], 32'd1, 1'b0};
         send_req(r, 1'b0, R_NONE);
         slot = pick_slot(0);
      end
      r.session = 16'($urandom_range(1, 16'hFFFF));
      r.file = 16'($urandom_range(1, 16'hFFFF));
      base = $urandom_range(1, 32'hFFFF_FF00);
      for (int i = 0; i < SLOTS + 2; i++) begin
         r.op = rlt_pkg::OP_ACQUIRE;
         r.record = base + 32'(i);
         r.kind = 1'($urandom_range(0, 1));
         send_req(r, 1'b0, R_NONE);
      end
      // another session runs into a lock while the table is full
      r.session = (r.session == 16'hFFFF) ? 16'd1 : r.session + 16'd1;
      r.record = base;
      send_req(r, 1'b0, R_NONE);
      r.op = rlt_pkg::OP_RELEASE_FILE;
      send_req(r, 1'b0, R_NONE);
   endtask

   // response side: random stall, then check against the oldest expectation
   initial begin
      int hold;
      lock_reply_type want;
      rsp_stall <= 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         hold = idle_cycles();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (replies_due.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_ok);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_removed_count !== want.removed) begin
               $error("removed_count: expected %0d, got %0d", want.removed,
                      rsp_removed_count);
               failures++;
            end
            if (rsp_holder_session !== want.holder_session) begin
               $error("holder_session: expected %0h, got %0h", want.holder_session,
                      rsp_holder_session);
               failures++;
            end
            if (rsp_holder_type !== want.holder_type) begin
               $error("holder_type: expected %0d, got %0d", want.holder_type,
                      rsp_holder_type);
               failures++;
            end
         end
         @(negedge clock);
      end
   end

   // request side: reset, directed table, random rounds, drain
   initial begin
      rlt_pkg::request_type r;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= rlt_pkg::OP_ACQUIRE;
      req_session_id <= '0;
      req_file_id    <= '0;
      req_record_id  <= '0;
      req_lock_type  <= 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i]) begin
         r = '{DIRECTED[i].op, DIRECTED[i].session, DIRECTED[i].file,
               DIRECTED[i].record, DIRECTED[i].kind};
         send_req(r, DIRECTED[i].typed, DIRECTED[i].reply);
      end

      // random rounds, some without idling, every other one ending in a fill
      for (int round = 0; round < 6; round++) begin
         quiet = (round == 2 || round == 5);
         for (int n = 0; n < 110; n++) send_req(random_request(), 1'b0, R_NONE);
         if (round % 2 == 1) fill_burst();
      end
      req_valid <= 1'b0;

      // drain
      while (replies_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests: %0d done, %0d invalid, %0d held, %0d not found, %0d full",
               requests_sent, status_hits[rlt_pkg::ST_DONE],
               status_hits[rlt_pkg::ST_INVALID], status_hits[rlt_pkg::ST_HELD],
               status_hits[rlt_pkg::ST_NOTFOUND], status_hits[rlt_pkg::ST_FULL]);
      $display("largest release-all freed %0d locks, %0d mismatches",
               largest_release, failures);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
